// ===== rtl/fbcs_pkg.sv =====
// constants shared by the forward/backward cumulative sum block
// no dependencies; imported by the top level for port widths and defaults
package fbcs_pkg;

  localparam int DEPTH_DEF        = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // port field widths
  localparam int SAMPLE_W    = 32;
  localparam int POS_W       = 10;
  localparam int VALUE_W     = 64;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - VALUE_W;

  // request kinds carried on in_tuser
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

endpackage

// ===== rtl/fbcs_ram.sv =====
// generic single-clock ram: one write port, one read port, registered read
// no dependencies; holds the stored prefix sums
module fbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/forward_backward_cumulative_sum.sv =====
// Forward/backward cumulative sum over a set of signed fixed-point samples.
//
// Input channel (in_*): in_tuser selects the request kind, 0 = push the
// sample on in_tdata, 1 = pull the next result. A push adds the sample to a
// running prefix and writes that prefix into the store.
// Pushes beyond DEPTH are dropped and set a sticky overflow flag.
// A pull reads the store from the last index down to 0 and returns the
// running suffix sum of prefixes; a pull with nothing left gives no result.
// A push after read-out has begun starts a new set.
// Output channel (out_*): tdata holds position and value, tlast marks
// index 0 and tuser carries the overflow flag.
// A pull issues the synchronous store read and moves to the read state,
// which adds the read data to the suffix sum and loads the output register.
// Throughput: one push per cycle while idle; in_tready stays low in the read
// state, so no request is taken until the pulled result is loaded.
// When the receiver stalls, the result waits in the output register; pushes
// are still taken, and a further pull waits in its read state until the
// output register frees up. Reset (synchronous, rst_n low) empties the set
// and clears the output; the store contents are left as they are.
module forward_backward_cumulative_sum #(
  parameter int DEPTH        = fbcs_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = fbcs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fbcs_pkg::SAMPLE_W-1:0]    in_tdata,  // [31:0] sample
  input  logic                             in_tuser,  // [0] mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fbcs_pkg::OUT_TDATA_W-1:0] out_tdata, // [9:0] position, [73:10] value
  output logic                             out_tlast,
  output logic                             out_tuser  // [0] overflowed
);

  import fbcs_pkg::*;

  localparam int AW       = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int EW       = (SAMPLE_WIDTH < SAMPLE_W) ? SAMPLE_WIDTH : SAMPLE_W;
  localparam int PREFIX_W = EW + AW + 1;
  localparam int PXW      = (AW > POS_W) ? AW : POS_W;

  typedef enum logic {S_IDLE, S_RD} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rp_r, rp_nxt;
  logic [PREFIX_W-1:0]  prefix_r, prefix_nxt;
  logic [VALUE_W-1:0]   suffix_r, suffix_nxt;
  logic                 draining_r, draining_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [PREFIX_W-1:0]  wr_data, rd_data;
  logic [CNT_W-1:0]     base_count, rp_eff, rp_dec;
  logic [PREFIX_W-1:0]  base_prefix, sample_ext;
  logic                 base_ovf;
  logic [PXW-1:0]       pos_wide;
  logic                 accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // a push during read-out restarts the set from empty
  assign base_count  = draining_r ? '0 : count_r;
  assign base_prefix = draining_r ? '0 : prefix_r;
  assign base_ovf    = draining_r ? 1'b0 : ovf_r;
  assign sample_ext  = PREFIX_W'($signed(in_tdata[EW-1:0]));
  assign rp_eff      = draining_r ? rp_r : count_r;
  assign rp_dec      = rp_eff - CNT_W'(1);
  assign pos_wide    = PXW'(rp_r[AW-1:0]);

  assign wr_addr = base_count[AW-1:0];
  assign wr_data = base_prefix + sample_ext;
  assign rd_addr = rp_dec[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    prefix_nxt    = prefix_r;
    suffix_nxt    = suffix_r;
    draining_nxt  = draining_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == MODE_PUSH) begin
            draining_nxt = 1'b0;
            if (base_count < CNT_W'(DEPTH)) begin
              wr_en      = 1'b1;
              prefix_nxt = wr_data;
              count_nxt  = base_count + CNT_W'(1);
              ovf_nxt    = base_ovf;
            end else begin
              prefix_nxt = base_prefix;
              count_nxt  = base_count;
              ovf_nxt    = 1'b1;
            end
          end else begin
            draining_nxt = 1'b1;
            if (!draining_r) begin
              suffix_nxt = '0;
            end
            rp_nxt = rp_eff;
            if (rp_eff != '0) begin
              rd_en     = 1'b1;
              rp_nxt    = rp_dec;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        // read data holds until the output register is free
        if (!out_valid_r || out_tready) begin
          suffix_nxt    = suffix_r + VALUE_W'($signed(rd_data));
          out_value_nxt = suffix_r + VALUE_W'($signed(rd_data));
          out_pos_nxt   = pos_wide[POS_W-1:0];
          out_last_nxt  = (rp_r == '0);
          out_ovf_nxt   = ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rp_r        <= '0;
      prefix_r    <= '0;
      suffix_r    <= '0;
      draining_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      prefix_r    <= prefix_nxt;
      suffix_r    <= suffix_nxt;
      draining_r  <= draining_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pos_r   <= out_pos_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // prefix store; reads and writes never share a cycle, so no forwarding
  fbcs_ram #(
    .WIDTH (PREFIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_value_r, out_pos_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count beyond store depth");

  a_read_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> rp_r < count_r)
    else $error("read pointer outside the stored set");

  a_read_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> state_r == S_RD)
    else $error("store read issued without waiting for data");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> !wr_en)
    else $error("store written while a read is outstanding");
`endif

endmodule

// ===== sim/fbcs_sum_checker.sv =====
// result checker for the forward/backward cumulative sum block
// watches both stream channels, predicts each result and compares it
// depends on fbcs_pkg for field widths and the request kinds
`timescale 1ns / 100ps

module fbcs_sum_checker #(
  parameter int DEPTH = fbcs_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fbcs_pkg::SAMPLE_W-1:0]    in_tdata,  // [31:0] sample
  input  logic                             in_tuser,  // [0] mode
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fbcs_pkg::OUT_TDATA_W-1:0] out_tdata, // [9:0] position, [73:10] value
  input  logic                             out_tlast,
  input  logic                             out_tuser, // [0] overflowed
  output int                               mismatches,
  output int                               sums_pending
);
  import fbcs_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic               final_res;
    logic               overflowed;
  } suffix_sum_t;

  logic [VALUE_W-1:0] prefix_mem [DEPTH];
  logic [VALUE_W-1:0] prefix_acc;
  logic [VALUE_W-1:0] suffix_acc;
  int                 fill_count;
  int                 read_idx;
  logic               reading_out;
  logic               dropped_push;
  suffix_sum_t        sums_due [$];
  int                 err_tally;

  always @(posedge clk) begin
    suffix_sum_t want;
    suffix_sum_t got;
    logic [VALUE_W-1:0] smp_ext;
    if (!rst_n) begin
      prefix_acc   = '0;
      suffix_acc   = '0;
      fill_count   = 0;
      read_idx     = 0;
      reading_out  = 1'b0;
      dropped_push = 1'b0;
      err_tally    = 0;
      sums_due.delete();
    end else begin
      // compare the delivered sum first, then predict from this request
      if (out_tvalid && out_tready) begin
        got.position   = out_tdata[POS_W-1:0];
        got.value      = out_tdata[POS_W +: VALUE_W];
        got.final_res  = out_tlast;
        got.overflowed = out_tuser;
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected result pos=%0d value=%0d", $time, got.position,
                   $signed(got.value));
          err_tally++;
        end else begin
          want = sums_due.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     got.position);
            err_tally++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value at %0d expected %0d actual %0d", $time, want.position,
                     $signed(want.value), $signed(got.value));
            err_tally++;
          end
          if (got.final_res !== want.final_res) begin
            $display("%0t: tlast at %0d expected %0b actual %0b", $time, want.position,
                     want.final_res, got.final_res);
            err_tally++;
          end
          if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflow at %0d expected %0b actual %0b", $time, want.position,
                     want.overflowed, got.overflowed);
            err_tally++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_PUSH) begin
          // a push after read-out has begun opens a fresh set
          if (reading_out) begin
            prefix_acc   = '0;
            suffix_acc   = '0;
            fill_count   = 0;
            read_idx     = 0;
            reading_out  = 1'b0;
            dropped_push = 1'b0;
          end
          if (fill_count < DEPTH) begin
            smp_ext = {{(VALUE_W-SAMPLE_W){in_tdata[SAMPLE_W-1]}}, in_tdata};
            prefix_acc = prefix_acc + smp_ext;
            prefix_mem[fill_count] = prefix_acc;
            fill_count++;
          end else begin
            dropped_push = 1'b1;
          end
        end else begin
          if (!reading_out) begin
            reading_out = 1'b1;
            read_idx    = fill_count;
            suffix_acc  = '0;
          end
          if (read_idx > 0) begin
            read_idx--;
            suffix_acc = suffix_acc + prefix_mem[read_idx];
            want.position   = read_idx[POS_W-1:0];
            want.value      = suffix_acc;
            want.final_res  = (read_idx == 0);
            want.overflowed = dropped_push;
            sums_due.push_back(want);
          end
        end
      end
    end
    mismatches   <= err_tally;
    sums_pending <= sums_due.size();
  end

endmodule

// ===== sim/forward_backward_cumulative_sum_test.sv =====
// top of the forward/backward cumulative sum testbench: clock, reset, stimulus
// and verdict; prediction and comparison live in fbcs_sum_checker
// depends on fbcs_pkg, the block and the checker
`timescale 1ns / 100ps

module forward_backward_cumulative_sum_test;
  import fbcs_pkg::*;

  localparam int RAND_ITEMS    = 600;
  localparam int NO_IDLE_ITEMS = 40;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_WAIT    = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  int   mismatches;
  int   sums_pending;
  int   quiet_cycles;
  int   hold_left;
  int   delivered;
  logic no_idle;

  forward_backward_cumulative_sum u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  fbcs_sum_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .sums_pending (sums_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off now and then so pulls back up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      delivered  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        delivered <= delivered + 1;
      end
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready &&
                   (delivered == 30 || delivered == 140 || delivered == 260)) begin
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  // watchdog on cycles with no request and no result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic offer(input logic kind, input logic [SAMPLE_W-1:0] smp);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(32) - 16;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n_items;
    int n_push;
    int n_pull;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_PUSH;
    rst_n     = 1'b0;
    no_idle   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pull, sample extremes, partial read-out, new set mid-drain,
    // pulls past the end, new set after a full read-out
    offer(MODE_PULL, 32'h0);
    offer(MODE_PUSH, 32'h7FFF_FFFF);
    offer(MODE_PUSH, 32'h8000_0000);
    offer(MODE_PUSH, 32'h0000_0000);
    offer(MODE_PUSH, 32'hFFFF_FFFF);
    offer(MODE_PUSH, 32'h5555_5555);
    offer(MODE_PUSH, 32'hAAAA_AAAA);
    repeat (3) offer(MODE_PULL, $urandom);
    offer(MODE_PUSH, 32'h0000_0001);
    offer(MODE_PUSH, 32'h0000_0007);
    repeat (4) offer(MODE_PULL, $urandom);
    offer(MODE_PUSH, 32'hFFFF_FFFB);
    repeat (2) offer(MODE_PULL, 32'hFFFF_FFFF);

    // random sets: mostly complete read-outs, some cut short or overrun
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      n_push = ($urandom_range(15) == 0) ? 0 : $urandom_range(24, 1);
      case ($urandom_range(9))
        0, 1:    n_pull = $urandom_range(n_push);
        2:       n_pull = n_push + $urandom_range(3, 1);
        default: n_pull = n_push;
      endcase
      repeat (n_push) offer(MODE_PUSH, pick_sample());
      repeat (n_pull) offer(MODE_PULL, $urandom);
      n_items += n_push + n_pull;
    end

    // one set run without idling on either side
    no_idle <= 1'b1;
    repeat (NO_IDLE_ITEMS) offer(MODE_PUSH, pick_sample());
    repeat (NO_IDLE_ITEMS) offer(MODE_PULL, $urandom);
    no_idle <= 1'b0;

    // a short set after a full read-out
    repeat (3) offer(MODE_PUSH, pick_sample());
    repeat (3) offer(MODE_PULL, $urandom);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && sums_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
